### hdl/ptr_pkg.sv
`default_nettype none

package ptr_pkg;

  // Output grid cap and derived widths
  localparam int MAX_DIM   = 256;
  localparam int DIM_LG    = $clog2(MAX_DIM);
  localparam int SH_W      = $clog2(DIM_LG + 3);
  localparam int SRC_AW    = 16;
  localparam int SRC_DEPTH = 1 << SRC_AW;
  localparam int PAL_AW    = 8;
  localparam int PAL_DEPTH = 1 << PAL_AW;
  localparam int DIM_W     = 9;

  // Item kinds
  localparam logic [1:0] KIND_PAL_WR = 2'd0;
  localparam logic [1:0] KIND_PIX_WR = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  // Register indexes
  localparam logic [1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_KEY        = 2'd2;

  localparam logic [7:0] KEY_INDEX = 8'hFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] pixel_address;
    logic [7:0]  color_index;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [7:0]  out_col;
    logic [7:0]  out_row;
  } in_word_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       coord_error;
  } out_word_t;

  // Store access request from the sequencer
  typedef struct packed {
    logic              src_we;
    logic              src_re;
    logic [SRC_AW-1:0] src_addr;
    logic [7:0]        src_wdata;
    logic              pal_we;
    logic [PAL_AW-1:0] pal_waddr;
    logic [23:0]       pal_wdata;
  } store_req_t;

  // One looked-up sample coming back from the stores
  typedef struct packed {
    logic        valid;
    logic        keyed;
    logic [23:0] rgb;
  } sample_t;

  // Force a dimension register into 1..256
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] v;
    v = d;
    if (d == '0) v = DIM_W'(1);
    else if (d > DIM_W'(256)) v = DIM_W'(256);
    return v;
  endfunction

  // Log2 of the grid size: next power of two at or above d, capped
  function automatic logic [SH_W-1:0] grid_lg(input logic [DIM_W-1:0] d);
    logic [SH_W-1:0] k;
    k = SH_W'(DIM_LG);
    for (int i = DIM_LG; i >= 0; i--) begin
      if ((32'd1 << i) >= {{(32-DIM_W){1'b0}}, d}) k = SH_W'(i);
    end
    return k;
  endfunction

endpackage

`default_nettype wire

### hdl/ptr_stores.sv
`default_nettype none

module ptr_stores (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ptr_pkg::store_req_t  req,
  input  logic                 key_en,
  output ptr_pkg::sample_t     smp
);
  import ptr_pkg::*;

  logic [7:0]        src_mem [0:SRC_DEPTH-1];
  logic [23:0]       pal_mem [0:PAL_DEPTH-1];

  logic [7:0]        src_q_r;
  logic              src_v_r;
  logic [23:0]       pal_q_r;
  logic              smp_v_r;
  logic              keyed_r;
  logic [PAL_AW-1:0] pal_addr;

  // Source image store: one port, write or read
  always_ff @(posedge clk) begin
    if (req.src_we) begin
      src_mem[req.src_addr] <= req.src_wdata;
    end else if (req.src_re) begin
      src_q_r <= src_mem[req.src_addr];
    end
  end

  // Palette store: one port, looked up by the fetched index
  assign pal_addr = req.pal_we ? req.pal_waddr : src_q_r;

  always_ff @(posedge clk) begin
    if (req.pal_we) begin
      pal_mem[pal_addr] <= req.pal_wdata;
    end else if (src_v_r) begin
      pal_q_r <= pal_mem[pal_addr];
      keyed_r <= key_en && (src_q_r == KEY_INDEX);
    end
  end

  // Track which read data is live
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_v_r <= 1'b0;
      smp_v_r <= 1'b0;
    end else begin
      src_v_r <= req.src_re && !req.src_we;
      smp_v_r <= src_v_r && !req.pal_we;
    end
  end

  assign smp.valid = smp_v_r;
  assign smp.keyed = keyed_r;
  assign smp.rgb   = pal_q_r;

endmodule

`default_nettype wire

### hdl/palette_texture_resample.sv
`default_nettype none

// Channel   Ports                             Word         Direction
// input     in_valid / in_stall / in_data     in_word_t    in
// result    out_valid / out_stall / out_data  out_word_t   out
// config    cfg_we / cfg_index / cfg_wdata    9-bit data   in
//
// Palette and pixel writes give no result and leave the block free for the next
// item. An on-grid read takes six steps on the one shared multiplier (four
// sample coordinates, two row bases), six fetch steps of chained source and
// palette lookups, then loads the output register; an off-grid read only loads it.
// Reset restores the default registers and the control state, not the stores.
// A waiting result blocks nothing; only a second finished read waits on out_stall.

module palette_texture_resample (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ptr_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ptr_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_wdata
);
  import ptr_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MUL   = 2'd1;
  localparam logic [1:0] ST_FETCH = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;
  localparam logic [2:0] STEP_LAST = 3'd5;

  logic [1:0]        state_r, state_nxt;
  logic [2:0]        step_r, step_nxt;

  logic [DIM_W-1:0]  width_r, height_r;
  logic              key_r;

  logic [7:0]        oc_r, orow_r;
  logic [7:0]        c1_r, c2_r, r1_r, r2_r;
  logic [15:0]       base1_r, base2_r;
  logic              err_r;
  logic [9:0]        acc_red_r, acc_green_r, acc_blue_r, acc_alpha_r;

  logic              out_valid_r;
  out_word_t         out_data_r;

  logic [DIM_W-1:0]  w_dim, h_dim;
  logic [SH_W-1:0]   lg_w, lg_h;
  logic              in_acc, is_read, off_grid, done_load;

  logic [9:0]        mul_a;
  logic [8:0]        mul_b;
  logic [SH_W-1:0]   mul_sh;
  logic [18:0]       prod;
  logic [18:0]       prod_sh;
  logic [15:0]       fetch_addr;

  store_req_t        store_req;
  sample_t           smp;

  // Effective dimensions and grid sizes
  assign w_dim = clamp_dim(width_r);
  assign h_dim = clamp_dim(height_r);
  assign lg_w  = grid_lg(w_dim);
  assign lg_h  = grid_lg(h_dim);

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign is_read   = (in_data.kind == KIND_READ);
  assign off_grid  = ((in_data.out_col >> lg_w) != 8'd0) ||
                     ((in_data.out_row >> lg_h) != 8'd0);
  assign done_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // Select operands of the shared multiplier
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_sh = '0;
    case (step_r)
      3'd0: begin
        mul_a  = {oc_r, 2'b01};
        mul_b  = w_dim;
        mul_sh = lg_w + SH_W'(2);
      end
      3'd1: begin
        mul_a  = {oc_r, 2'b11};
        mul_b  = w_dim;
        mul_sh = lg_w + SH_W'(2);
      end
      3'd2: begin
        mul_a  = {orow_r, 2'b01};
        mul_b  = h_dim;
        mul_sh = lg_h + SH_W'(2);
      end
      3'd3: begin
        mul_a  = {orow_r, 2'b11};
        mul_b  = h_dim;
        mul_sh = lg_h + SH_W'(2);
      end
      3'd4: begin
        mul_a  = {2'b00, r1_r};
        mul_b  = w_dim;
      end
      3'd5: begin
        mul_a  = {2'b00, r2_r};
        mul_b  = w_dim;
      end
      default: begin
        mul_a  = '0;
      end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign prod_sh = prod >> mul_sh;

  // Pick the sample address for this fetch step
  always_comb begin
    case (step_r[1:0])
      2'd0:    fetch_addr = base1_r + {8'd0, c1_r};
      2'd1:    fetch_addr = base1_r + {8'd0, c2_r};
      2'd2:    fetch_addr = base2_r + {8'd0, c1_r};
      default: fetch_addr = base2_r + {8'd0, c2_r};
    endcase
  end

  // Build the store request
  always_comb begin
    store_req.src_we    = in_acc && (in_data.kind == KIND_PIX_WR);
    store_req.src_re    = (state_r == ST_FETCH) && !step_r[2];
    store_req.src_addr  = store_req.src_re ? fetch_addr : in_data.pixel_address;
    store_req.src_wdata = in_data.color_index;
    store_req.pal_we    = in_acc && (in_data.kind == KIND_PAL_WR);
    store_req.pal_waddr = in_data.color_index;
    store_req.pal_wdata = {in_data.red_in, in_data.green_in, in_data.blue_in};
  end

  ptr_stores u_stores (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (store_req),
    .key_en (key_r),
    .smp    (smp)
  );

  // Sequence one read through multiply, fetch and load; an off-grid read goes straight to load
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (in_acc && is_read) begin
          state_nxt = off_grid ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL: begin
        step_nxt = step_r + 3'd1;
        if (step_r == STEP_LAST) begin
          state_nxt = ST_FETCH;
          step_nxt  = '0;
        end
      end
      ST_FETCH: begin
        step_nxt = step_r + 3'd1;
        if (step_r == STEP_LAST) begin
          state_nxt = ST_DONE;
          step_nxt  = '0;
        end
      end
      ST_DONE: begin
        if (done_load) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
        step_nxt  = '0;
      end
    endcase
  end

  // Control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      width_r     <= DIM_W'(16);
      height_r    <= DIM_W'(16);
      key_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (done_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_SRC_WIDTH:  width_r  <= cfg_wdata;
          CFG_SRC_HEIGHT: height_r <= cfg_wdata;
          CFG_KEY:        key_r    <= cfg_wdata[0];
          default:        ;
        endcase
      end
    end
  end

  // Capture the request, hold multiplier results
  always_ff @(posedge clk) begin
    if (in_acc && is_read) begin
      oc_r   <= in_data.out_col;
      orow_r <= in_data.out_row;
      err_r  <= off_grid;
    end
    if (state_r == ST_MUL) begin
      case (step_r)
        3'd0:    c1_r    <= prod_sh[7:0];
        3'd1:    c2_r    <= prod_sh[7:0];
        3'd2:    r1_r    <= prod_sh[7:0];
        3'd3:    r2_r    <= prod_sh[7:0];
        3'd4:    base1_r <= prod[15:0];
        3'd5:    base2_r <= prod[15:0];
        default: ;
      endcase
    end
  end

  // Accumulate opaque samples; drop keyed ones
  always_ff @(posedge clk) begin
    if (in_acc && is_read) begin
      acc_red_r   <= '0;
      acc_green_r <= '0;
      acc_blue_r  <= '0;
      acc_alpha_r <= '0;
    end else if (smp.valid && !smp.keyed) begin
      acc_red_r   <= acc_red_r   + {2'b00, smp.rgb[23:16]};
      acc_green_r <= acc_green_r + {2'b00, smp.rgb[15:8]};
      acc_blue_r  <= acc_blue_r  + {2'b00, smp.rgb[7:0]};
      acc_alpha_r <= acc_alpha_r + 10'd255;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (done_load) begin
      out_data_r.red_out     <= acc_red_r[9:2];
      out_data_r.green_out   <= acc_green_r[9:2];
      out_data_r.blue_out    <= acc_blue_r[9:2];
      out_data_r.alpha_out   <= acc_alpha_r[9:2];
      out_data_r.coord_error <= err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result loaded outside the done state");

  a_sample_in_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    smp.valid |-> state_r == ST_FETCH)
    else $error("sample returned outside fetch");

  a_src_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(store_req.src_we && store_req.src_re))
    else $error("source store written and read together");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.coord_error) |->
      (out_data_r.red_out == 8'd0 && out_data_r.green_out == 8'd0 &&
       out_data_r.blue_out == 8'd0 && out_data_r.alpha_out == 8'd0))
    else $error("off-grid result carries color");

  a_alpha_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.alpha_out == 8'd0 || out_data_r.alpha_out == 8'd63 ||
                     out_data_r.alpha_out == 8'd127 || out_data_r.alpha_out == 8'd191 ||
                     out_data_r.alpha_out == 8'd255))
    else $error("alpha not a quarter step");

endmodule

`default_nettype wire
